// File: hdl/pvahp_pkg.sv
// pvahp_pkg: shared types and constants for the pva packet header parser
// holds the config register set, the result record and the record codes
// no dependencies
package pvahp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SYNC_WORD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_VIDEO_ID    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_AUDIO_ID    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_PAYLOAD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RESYNC      = 3'd4;

  localparam logic [15:0] SYNC_WORD_RST   = 16'h4156;
  localparam logic [7:0]  VIDEO_ID_RST    = 8'd1;
  localparam logic [7:0]  AUDIO_ID_RST    = 8'd2;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd6136;
  localparam logic        RESYNC_RST      = 1'b1;

  // pes header data bytes that carry the pts
  localparam int PES_PTS_BYTES = 5;
  localparam int HEAD_IDX_W    = $clog2(PES_PTS_BYTES);

  localparam logic [7:0]  RSV_BYTE       = 8'h55;
  localparam int          VPTS_FLAG_BIT  = 4;
  localparam int          PES_PTS_BIT    = 7;
  localparam logic [7:0]  PTS_MARK_MASK  = 8'hf0;
  localparam logic [7:0]  PTS_MARK       = 8'h20;
  localparam logic [23:0] PES_START_CODE = 24'h000001;

  typedef enum logic [1:0] {
    KIND_HDR     = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERR     = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_SYNC = 3'd1,
    ST_BAD_ID   = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_BAD_PES  = 3'd4
  } status_t;

  typedef struct packed {
    logic [15:0] sync_word;
    logic [7:0]  video_id;
    logic [7:0]  audio_id;
    logic [15:0] max_payload;
    logic        resync_on_bad_pes;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  stream_id;
    logic [15:0] payload_len;
    logic [32:0] pts;
    logic        pts_valid;
    status_t     status;
    logic        reserved_warning;
    logic        audio_corrupt_warning;
    logic        length_clamped;
    logic [7:0]  payload_byte;
    logic        last_of_payload;
  } res_t;

endpackage

// File: hdl/pvahp_parser.sv
// pvahp_parser: per-byte parse state and record generation
// one stream byte per accepted item, at most one record out
// depends on pvahp_pkg
module pvahp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [7:0]        in_byte,
  input  pvahp_pkg::cfg_t   cfg,
  output logic              res_vld,
  output pvahp_pkg::res_t   res
);
  import pvahp_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR, PH_VPTS, PH_PESFIX, PH_PESDATA, PH_PAYLOAD, PH_SKIP
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [7:0]         cnt_r, cnt_nxt;
  logic [55:0]        hdr_r, hdr_nxt;
  logic [7:0]         sid_r, sid_nxt;
  logic               rsv_r, rsv_nxt;
  logic               pts_ok_r, pts_ok_nxt;
  logic               audio_r, audio_nxt;
  logic signed [17:0] len_r, len_nxt;
  logic [15:0]        len_out_r, len_out_nxt;
  logic signed [17:0] pes_rem_r, pes_rem_nxt;
  logic [23:0]        sig_r, sig_nxt;
  logic [15:0]        pkt_len_r, pkt_len_nxt;
  logic               pes_pts_r, pes_pts_nxt;
  logic [7:0]         hdl_r, hdl_nxt;
  logic [7:0]         head_r [PES_PTS_BYTES];
  logic [7:0]         head_nxt [PES_PTS_BYTES];
  logic [32:0]        ts_r, ts_nxt;
  logic [15:0]        left_r, left_nxt;

  logic               fin_req, fin_audio, fin_pts_ok;
  logic signed [17:0] fin_len, pes_diff;
  logic [32:0]        fin_ts;
  logic               skip_req;
  logic signed [17:0] skip_n;
  logic [7:0]         eff [PES_PTS_BYTES];
  logic [15:0]        hsw, hln;
  logic [7:0]         hsid, hrsv, hfl;
  logic [7:0]         cnt_inc;
  logic [15:0]        left_dec;
  logic [15:0]        fin_lo;

  assign hsw      = hdr_r[55:40];
  assign hsid     = hdr_r[39:32];
  assign hrsv     = hdr_r[23:16];
  assign hfl      = hdr_r[15:8];
  assign hln      = {hdr_r[7:0], in_byte};
  assign cnt_inc  = cnt_r + 8'd1;
  assign left_dec = left_r - 16'd1;

  always_comb begin
    for (int k = 0; k < PES_PTS_BYTES; k++) begin
      eff[k] = (cnt_r == 8'(k)) ? in_byte : head_r[k];
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    hdr_nxt      = hdr_r;
    sid_nxt      = sid_r;
    rsv_nxt      = rsv_r;
    pts_ok_nxt   = pts_ok_r;
    audio_nxt    = audio_r;
    len_nxt      = len_r;
    len_out_nxt  = len_out_r;
    pes_rem_nxt  = pes_rem_r;
    sig_nxt      = sig_r;
    pkt_len_nxt  = pkt_len_r;
    pes_pts_nxt  = pes_pts_r;
    hdl_nxt      = hdl_r;
    head_nxt     = head_r;
    ts_nxt       = ts_r;
    left_nxt     = left_r;
    res_vld      = 1'b0;
    res          = '0;
    fin_req      = 1'b0;
    fin_len      = len_r;
    fin_audio    = audio_r;
    fin_pts_ok   = 1'b0;
    fin_ts       = ts_r;
    skip_req     = 1'b0;
    skip_n       = '0;
    pes_diff     = '0;
    fin_lo       = '0;

    if (in_fire) begin
      case (phase_r)
        PH_VPTS: begin
          ts_nxt  = {1'b0, ts_r[23:0], in_byte};
          cnt_nxt = cnt_inc;
          if (cnt_r == 8'd3) begin
            fin_req    = 1'b1;
            fin_len    = len_r - 18'sd4;
            fin_pts_ok = 1'b1;
            fin_ts     = {1'b0, ts_r[23:0], in_byte};
          end
        end

        PH_PESFIX: begin
          cnt_nxt = cnt_inc;
          if (cnt_r < 8'd3) begin
            sig_nxt = {sig_r[15:0], in_byte};
          end else if (cnt_r == 8'd4 || cnt_r == 8'd5) begin
            pkt_len_nxt = {pkt_len_r[7:0], in_byte};
          end else if (cnt_r == 8'd7) begin
            pes_pts_nxt = in_byte[PES_PTS_BIT];
          end else if (cnt_r == 8'd8) begin
            cnt_nxt = '0;
            hdl_nxt = in_byte;
            if (sig_r != PES_START_CODE || in_byte == 8'd0) begin
              skip_req = 1'b1;
              skip_n   = len_r - 18'sd9;
              if (!cfg.resync_on_bad_pes) begin
                res_vld                = 1'b1;
                res.kind               = KIND_ERR;
                res.status             = ST_BAD_PES;
                res.reserved_warning   = rsv_r;
              end
            end else begin
              phase_nxt   = PH_PESDATA;
              len_nxt     = len_r - 18'sd9 - $signed({10'd0, in_byte});
              pes_rem_nxt = $signed({2'b00, pkt_len_r}) - 18'sd3
                            - $signed({10'd0, in_byte});
            end
          end
        end

        PH_PESDATA: begin
          if (cnt_r < 8'(PES_PTS_BYTES)) begin
            head_nxt[cnt_r[HEAD_IDX_W-1:0]] = in_byte;
          end
          if (cnt_inc < hdl_r) begin
            cnt_nxt = cnt_inc;
          end else begin
            cnt_nxt = '0;
            if (pes_pts_r && ((eff[0] & PTS_MARK_MASK) == PTS_MARK)) begin
              if (hdl_r < 8'(PES_PTS_BYTES)) begin
                skip_req             = 1'b1;
                skip_n               = len_r;
                res_vld              = 1'b1;
                res.kind             = KIND_ERR;
                res.status           = ST_BAD_PES;
                res.reserved_warning = rsv_r;
              end else begin
                fin_req    = 1'b1;
                fin_pts_ok = 1'b1;
                fin_ts     = {eff[0][3:1], eff[1], eff[2][7:1], eff[3], eff[4][7:1]};
              end
            end else begin
              fin_req = 1'b1;
            end
          end
        end

        PH_PAYLOAD: begin
          left_nxt            = left_dec;
          res_vld             = 1'b1;
          res.kind            = KIND_PAYLOAD;
          res.payload_len     = len_out_r;
          res.payload_byte    = in_byte;
          res.last_of_payload = (left_dec == 16'd0);
          if (left_dec == 16'd0) begin
            phase_nxt = PH_HDR;
          end
        end

        PH_SKIP: begin
          left_nxt = left_dec;
          if (left_dec == 16'd0) begin
            phase_nxt = PH_HDR;
          end
        end

        default: begin
          phase_nxt = PH_HDR;
          hdr_nxt   = {hdr_r[47:0], in_byte};
          cnt_nxt   = cnt_inc;
          if (cnt_r == 8'd7) begin
            cnt_nxt    = '0;
            sid_nxt    = hsid;
            pts_ok_nxt = 1'b0;
            if (hsw != cfg.sync_word) begin
              res_vld    = 1'b1;
              res.kind   = KIND_ERR;
              res.status = ST_BAD_SYNC;
            end else if (hsid != cfg.video_id && hsid != cfg.audio_id) begin
              res_vld    = 1'b1;
              res.kind   = KIND_ERR;
              res.status = ST_BAD_ID;
            end else begin
              rsv_nxt = (hrsv != RSV_BYTE);
              if (hln > cfg.max_payload) begin
                res_vld              = 1'b1;
                res.kind             = KIND_ERR;
                res.status           = ST_TOO_LONG;
                res.reserved_warning = (hrsv != RSV_BYTE);
              end else begin
                len_nxt   = $signed({2'b00, hln});
                audio_nxt = (hsid != cfg.video_id);
                fin_len   = $signed({2'b00, hln});
                fin_audio = (hsid != cfg.video_id);
                if (hsid == cfg.video_id) begin
                  if (hfl[VPTS_FLAG_BIT]) begin
                    phase_nxt = PH_VPTS;
                  end else begin
                    fin_req = 1'b1;
                  end
                end else if (pes_rem_r != 18'sd0) begin
                  fin_req = 1'b1;
                end else begin
                  phase_nxt = PH_PESFIX;
                end
              end
            end
          end
        end
      endcase

      if (skip_req) begin
        cnt_nxt   = '0;
        pts_ok_nxt = 1'b0;
        if (!skip_n[17] && skip_n != 18'sd0) begin
          left_nxt  = skip_n[15:0];
          phase_nxt = PH_SKIP;
        end else begin
          left_nxt  = '0;
          phase_nxt = PH_HDR;
        end
      end

      if (fin_req) begin
        pes_diff = pes_rem_r - fin_len;
        if (fin_audio) begin
          pes_rem_nxt = pes_diff[17] ? 18'sd0 : pes_diff;
        end
        fin_lo      = fin_len[17] ? 16'd0 : fin_len[15:0];
        cnt_nxt     = '0;
        pts_ok_nxt  = fin_pts_ok;
        ts_nxt      = fin_ts;
        len_out_nxt = fin_lo;
        left_nxt    = fin_lo;
        phase_nxt   = (fin_lo != 16'd0) ? PH_PAYLOAD : PH_HDR;
        res_vld                   = 1'b1;
        res.kind                  = KIND_HDR;
        res.payload_len           = fin_lo;
        res.pts                   = fin_pts_ok ? fin_ts : 33'd0;
        res.pts_valid             = fin_pts_ok;
        res.status                = ST_OK;
        res.reserved_warning      = rsv_nxt;
        res.audio_corrupt_warning = fin_audio && pes_diff[17];
        res.length_clamped        = fin_len[17];
      end

      res.stream_id = sid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR;
      cnt_r     <= '0;
      pes_rem_r <= '0;
      left_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      pes_rem_r <= pes_rem_nxt;
      left_r    <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r      <= hdr_nxt;
    sid_r      <= sid_nxt;
    rsv_r      <= rsv_nxt;
    pts_ok_r   <= pts_ok_nxt;
    audio_r    <= audio_nxt;
    len_r      <= len_nxt;
    len_out_r  <= len_out_nxt;
    sig_r      <= sig_nxt;
    pkt_len_r  <= pkt_len_nxt;
    pes_pts_r  <= pes_pts_nxt;
    hdl_r      <= hdl_nxt;
    head_r     <= head_nxt;
    ts_r       <= ts_nxt;
  end

endmodule

// File: hdl/pvahp_out_buf.sv
// pvahp_out_buf: result register with one skid entry
// decouples output stall from input acceptance
// depends on pvahp_pkg
module pvahp_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pvahp_pkg::res_t push_data,
  output logic            full,
  output logic            out_vld,
  input  logic            out_stall,
  output pvahp_pkg::res_t out_data
);
  import pvahp_pkg::*;

  logic out_vld_r, out_vld_nxt;
  logic sk_vld_r, sk_vld_nxt;
  res_t out_r, out_nxt;
  res_t sk_r, sk_nxt;

  always_comb begin
    out_vld_nxt = out_vld_r;
    sk_vld_nxt  = sk_vld_r;
    out_nxt     = out_r;
    sk_nxt      = sk_r;
    if (!out_vld_r || !out_stall) begin
      if (sk_vld_r) begin
        out_vld_nxt = 1'b1;
        out_nxt     = sk_r;
        sk_vld_nxt  = 1'b0;
      end else begin
        out_vld_nxt = push;
        out_nxt     = push_data;
      end
    end else if (push) begin
      sk_vld_nxt = 1'b1;
      sk_nxt     = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      sk_vld_r  <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      sk_vld_r  <= sk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    sk_r  <= sk_nxt;
  end

  assign full     = sk_vld_r;
  assign out_vld  = out_vld_r;
  assign out_data = out_r;

endmodule

// File: hdl/pva_packet_header_parser.sv
// PVA packet header parser. Takes one stream byte per cycle on the in_ channel and
// emits one header record per good packet followed by one record per payload byte,
// or an error record, on the out_ channel. A byte is taken every cycle as long as
// the output side keeps up: the result register plus one skid entry let a byte in
// while a record waits, and in_stall rises only when both are full. Each byte
// updates the parser state registers; a record that it causes is registered in the
// result register or skid entry. Configuration writes on cfg_ are registered and
// are meant for idle times. Depends on pvahp_pkg, pvahp_parser and pvahp_out_buf.
module pva_packet_header_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [pvahp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pvahp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_data_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_kind,
  output logic [7:0]                       out_stream_id,
  output logic [15:0]                      out_payload_len,
  output logic [32:0]                      out_pts,
  output logic                             out_pts_valid,
  output logic [2:0]                       out_status,
  output logic                             out_reserved_warning,
  output logic                             out_audio_corrupt_warning,
  output logic                             out_length_clamped,
  output logic [7:0]                       out_payload_byte,
  output logic                             out_last_of_payload
);
  import pvahp_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic in_fire;
  logic res_vld;
  res_t res;
  res_t out_data;
  logic buf_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IDX_SYNC_WORD:   cfg_nxt.sync_word         = cfg_data;
        CFG_IDX_VIDEO_ID:    cfg_nxt.video_id          = cfg_data[7:0];
        CFG_IDX_AUDIO_ID:    cfg_nxt.audio_id          = cfg_data[7:0];
        CFG_IDX_MAX_PAYLOAD: cfg_nxt.max_payload       = cfg_data;
        CFG_IDX_RESYNC:      cfg_nxt.resync_on_bad_pes = cfg_data[0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_word         <= SYNC_WORD_RST;
      cfg_r.video_id          <= VIDEO_ID_RST;
      cfg_r.audio_id          <= AUDIO_ID_RST;
      cfg_r.max_payload       <= MAX_PAYLOAD_RST;
      cfg_r.resync_on_bad_pes <= RESYNC_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = buf_full;
  assign in_fire  = in_valid && !buf_full;

  pvahp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_data_byte),
    .cfg     (cfg_r),
    .res_vld (res_vld),
    .res     (res)
  );

  pvahp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .full      (buf_full),
    .out_vld   (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_kind                  = out_data.kind;
  assign out_stream_id             = out_data.stream_id;
  assign out_payload_len           = out_data.payload_len;
  assign out_pts                   = out_data.pts;
  assign out_pts_valid             = out_data.pts_valid;
  assign out_status                = out_data.status;
  assign out_reserved_warning      = out_data.reserved_warning;
  assign out_audio_corrupt_warning = out_data.audio_corrupt_warning;
  assign out_length_clamped        = out_data.length_clamped;
  assign out_payload_byte          = out_data.payload_byte;
  assign out_last_of_payload       = out_data.last_of_payload;

  // skid entry only fills behind a held result
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty result register");

  a_pts_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_pts_valid) |-> (out_pts == 33'd0))
    else $error("pts nonzero without pts_valid");

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_ERR) |->
      (out_payload_len == 16'd0 && !out_last_of_payload && out_status != ST_OK))
    else $error("malformed error record");

  a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_PAYLOAD) |->
      (out_status == ST_OK && !out_pts_valid && out_payload_len != 16'd0))
    else $error("malformed payload record");

endmodule
